// ===== hw/rtl/tsq_pkg.sv =====
// Shared types and constants for the thick segment to quad expander.
// Used by tsq_ctrl, tsq_dp and thick_segment_to_quad; no dependencies.
package tsq_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int COORD_W     = 18;
  localparam int HW_W        = 14;
  localparam int IDX_OUT_W   = 16;
  localparam logic [HW_W-1:0] HW_RESET = 14'd164;

  localparam int SQRT_STEPS  = 27;
  localparam int DIV_STEPS   = 15;
  localparam int STEP_CNT_W  = 5;

  localparam logic [2:0] EMIT_FIRST_TRI = 3'd4;
  localparam logic [2:0] EMIT_LAST      = 3'd5;
  localparam logic       KIND_VERTEX    = 1'b0;
  localparam logic       KIND_TRI       = 1'b1;
  localparam logic       ACTION_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clear_count;
    logic       bump_count;
    logic       square;
    logic       root_init;
    logic       root_step;
    logic       mult;
    logic       div_init;
    logic       div_step;
    logic [2:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic zero_len;
  } status_t;

endpackage

// ===== hw/rtl/tsq_ctrl.sv =====
// Sequencer for the quad expander: steps check, square, root, multiply, divide and emit phases.
// Depends on tsq_pkg; drives the command struct into tsq_dp.
module tsq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_stall,
  input  tsq_pkg::status_t status,
  output tsq_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             out_valid
);

  tsq_pkg::state_t state_r, state_nxt;
  logic [tsq_pkg::STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0] emit_r, emit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsq_pkg::ST_IDLE;
      cnt_r   <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tsq_pkg::ST_CHECK;
      end
      tsq_pkg::ST_CHECK: begin
        if (status.restart || status.zero_len) state_nxt = tsq_pkg::ST_IDLE;
        else state_nxt = tsq_pkg::ST_SQ;
      end
      tsq_pkg::ST_SQ:        state_nxt = tsq_pkg::ST_ROOT_INIT;
      tsq_pkg::ST_ROOT_INIT: state_nxt = tsq_pkg::ST_ROOT;
      tsq_pkg::ST_ROOT: begin
        if (cnt_r == tsq_pkg::STEP_CNT_W'(tsq_pkg::SQRT_STEPS - 1))
          state_nxt = tsq_pkg::ST_MUL;
      end
      tsq_pkg::ST_MUL:       state_nxt = tsq_pkg::ST_DIV_INIT;
      tsq_pkg::ST_DIV_INIT:  state_nxt = tsq_pkg::ST_DIV;
      tsq_pkg::ST_DIV: begin
        if (cnt_r == tsq_pkg::STEP_CNT_W'(tsq_pkg::DIV_STEPS - 1))
          state_nxt = tsq_pkg::ST_EMIT;
      end
      tsq_pkg::ST_EMIT: begin
        if (!out_stall && emit_r == tsq_pkg::EMIT_LAST) state_nxt = tsq_pkg::ST_IDLE;
      end
      default: state_nxt = tsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    emit_nxt = emit_r;
    unique case (state_r)
      tsq_pkg::ST_ROOT_INIT, tsq_pkg::ST_DIV_INIT: cnt_nxt = '0;
      tsq_pkg::ST_ROOT, tsq_pkg::ST_DIV:           cnt_nxt = cnt_r + 1'b1;
      tsq_pkg::ST_MUL:                             emit_nxt = '0;
      tsq_pkg::ST_EMIT: begin
        if (!out_stall) emit_nxt = emit_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_idx = emit_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      tsq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tsq_pkg::ST_CHECK:     cmd.clear_count = status.restart;
      tsq_pkg::ST_SQ:        cmd.square = 1'b1;
      tsq_pkg::ST_ROOT_INIT: cmd.root_init = 1'b1;
      tsq_pkg::ST_ROOT:      cmd.root_step = 1'b1;
      tsq_pkg::ST_MUL:       cmd.mult = 1'b1;
      tsq_pkg::ST_DIV_INIT:  cmd.div_init = 1'b1;
      tsq_pkg::ST_DIV:       cmd.div_step = 1'b1;
      tsq_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.bump_count = !out_stall && emit_r == tsq_pkg::EMIT_LAST;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/tsq_dp.sv =====
// Datapath for the quad expander: squares, bit-serial root, restoring
// divide, vertex saturation and index counter. Depends on tsq_pkg.
module tsq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsq_pkg::cmd_t                       cmd,
  output tsq_pkg::status_t                    status,
  input  logic                                cfg_wr_en,
  input  logic [tsq_pkg::HW_W-1:0]            cfg_wr_data,
  input  logic                                in_action,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_y,
  output logic                                out_kind,
  output logic signed [tsq_pkg::COORD_W-1:0]  out_vert_x,
  output logic signed [tsq_pkg::COORD_W-1:0]  out_vert_y,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_a,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_b,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_c,
  output logic                                out_last
);

  logic [tsq_pkg::HW_W-1:0] hw_r;
  logic [tsq_pkg::INDEX_BITS-1:0] base_r;
  logic action_r;
  logic signed [17:0] sx_r, sy_r, ex_r, ey_r;
  logic [37:0] dx2_r, dy2_r;
  logic [53:0] v_r, res_r, bit_r, root_try;
  logic [31:0] numx_r, numy_r;
  logic [41:0] remx_r, remy_r, dsh_r;
  logic [14:0] qx_r, qy_r;

  logic signed [18:0] dx, dy;
  logic [18:0] magdx, magdy;
  logic [26:0] len;
  logic signed [15:0] ox, oy, osel_x, osel_y;
  logic signed [17:0] px, py;
  logic signed [19:0] sumx, sumy;
  logic plus;

  assign dx = 19'(ex_r) - 19'(sx_r);
  assign dy = 19'(ey_r) - 19'(sy_r);
  assign magdx = dx[18] ? 19'(-dx) : dx;
  assign magdy = dy[18] ? 19'(-dy) : dy;
  assign len = res_r[26:0];
  assign root_try = res_r + bit_r;

  assign status.restart  = action_r == tsq_pkg::ACTION_RESTART;
  assign status.zero_len = dx == '0 && dy == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= tsq_pkg::HW_RESET;
      base_r <= '0;
    end else begin
      if (cfg_wr_en) hw_r <= cfg_wr_data;
      if (cmd.clear_count) base_r <= '0;
      else if (cmd.bump_count) base_r <= base_r + tsq_pkg::INDEX_BITS'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
    end
    if (cmd.square) begin
      dx2_r <= 38'(dx * dx);
      dy2_r <= 38'(dy * dy);
    end
    if (cmd.root_init) begin
      v_r   <= {dx2_r + dy2_r, 16'b0};
      res_r <= '0;
      bit_r <= 54'(1) << 52;
    end else if (cmd.root_step) begin
      if (v_r >= root_try) begin
        v_r   <= v_r - root_try;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mult) begin
      numx_r <= 32'(magdy * hw_r);
      numy_r <= 32'(magdx * hw_r);
    end
    // rounded quotient: (2*num*256 + L) / (2*L), quotient fits 15 bits
    if (cmd.div_init) begin
      remx_r <= 42'({numx_r, 9'b0}) + 42'(len);
      remy_r <= 42'({numy_r, 9'b0}) + 42'(len);
      dsh_r  <= {len, 15'b0};
    end else if (cmd.div_step) begin
      if (remx_r >= dsh_r) begin
        remx_r <= remx_r - dsh_r;
        qx_r   <= {qx_r[13:0], 1'b1};
      end else begin
        qx_r   <= {qx_r[13:0], 1'b0};
      end
      if (remy_r >= dsh_r) begin
        remy_r <= remy_r - dsh_r;
        qy_r   <= {qy_r[13:0], 1'b1};
      end else begin
        qy_r   <= {qy_r[13:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // offset is the perpendicular (-dy, dx) scaled
  assign ox = dy[18] ? $signed({1'b0, qx_r}) : -$signed({1'b0, qx_r});
  assign oy = dx[18] ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});

  always_comb begin
    plus   = cmd.emit_idx == 3'd0 || cmd.emit_idx == 3'd3;
    px     = (cmd.emit_idx < 3'd2) ? sx_r : ex_r;
    py     = (cmd.emit_idx < 3'd2) ? sy_r : ey_r;
    osel_x = plus ? ox : -ox;
    osel_y = plus ? oy : -oy;
    sumx   = 20'(px) + 20'(osel_x);
    sumy   = 20'(py) + 20'(osel_y);
  end

  function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) return 18'sd131071;
    if (v < -20'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  always_comb begin
    out_kind     = (cmd.emit_idx >= tsq_pkg::EMIT_FIRST_TRI) ? tsq_pkg::KIND_TRI
                                                             : tsq_pkg::KIND_VERTEX;
    out_last     = cmd.emit_idx == tsq_pkg::EMIT_LAST;
    out_vert_x   = '0;
    out_vert_y   = '0;
    out_corner_a = '0;
    out_corner_b = '0;
    out_corner_c = '0;
    if (out_kind == tsq_pkg::KIND_VERTEX) begin
      out_vert_x = sat18(sumx);
      out_vert_y = sat18(sumy);
    end else begin
      out_corner_a = tsq_pkg::IDX_OUT_W'(base_r);
      if (out_last) begin
        out_corner_b = tsq_pkg::IDX_OUT_W'(base_r + tsq_pkg::INDEX_BITS'(2));
        out_corner_c = tsq_pkg::IDX_OUT_W'(base_r + tsq_pkg::INDEX_BITS'(3));
      end else begin
        out_corner_b = tsq_pkg::IDX_OUT_W'(base_r + tsq_pkg::INDEX_BITS'(1));
        out_corner_c = tsq_pkg::IDX_OUT_W'(base_r + tsq_pkg::INDEX_BITS'(2));
      end
    end
  end

endmodule

// ===== hw/rtl/thick_segment_to_quad.sv =====
// Top level of the thick segment to quad expander.
// Depends on tsq_pkg, tsq_ctrl and tsq_dp.
//
// One segment at a time: after acceptance a segment passes through a check
// state, a squaring state, the bit-serial square root, a multiply state
// and the restoring divider (both offset components in parallel), then
// six result transactions, which wait while the output is stalled. The
// next segment is accepted only after the last result has been taken. A
// restart or a zero-length segment yields no result.
// in_stall is low only while the block is idle.
module thick_segment_to_quad (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tsq_pkg::HW_W-1:0]            cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic signed [tsq_pkg::COORD_W-1:0]  out_vert_x,
  output logic signed [tsq_pkg::COORD_W-1:0]  out_vert_y,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_a,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_b,
  output logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_c,
  output logic                                out_last
);

  tsq_pkg::cmd_t    cmd;
  tsq_pkg::status_t status;

  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  tsq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_action    (in_action),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_kind     (out_kind),
    .out_vert_x   (out_vert_x),
    .out_vert_y   (out_vert_y),
    .out_corner_a (out_corner_a),
    .out_corner_b (out_corner_b),
    .out_corner_c (out_corner_c),
    .out_last     (out_last)
  );

endmodule

// ===== test/tsq_checker.sv =====
// Checker for thick_segment_to_quad: watches both channels, predicts the quad
// results of each accepted segment and compares them. Depends on tsq_pkg.
`timescale 1ns / 1ps
module tsq_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tsq_pkg::HW_W-1:0]            cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  in_end_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_kind,
  input  logic signed [tsq_pkg::COORD_W-1:0]  out_vert_x,
  input  logic signed [tsq_pkg::COORD_W-1:0]  out_vert_y,
  input  logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_a,
  input  logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_b,
  input  logic [tsq_pkg::IDX_OUT_W-1:0]       out_corner_c,
  input  logic                                out_last,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  quads_seen
);
  import tsq_pkg::*;

  typedef struct packed {
    logic                       kind;
    logic signed [COORD_W-1:0]  vx;
    logic signed [COORD_W-1:0]  vy;
    logic [IDX_OUT_W-1:0]       ca;
    logic [IDX_OUT_W-1:0]       cb;
    logic [IDX_OUT_W-1:0]       cc;
    logic                       last;
  } quad_item_t;

  quad_item_t            expected_q[$];
  logic [HW_W-1:0]       hw_model;
  logic [INDEX_BITS-1:0] vcount_model;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint offset_of(longint comp, logic [63:0] len);
    logic [63:0] mag, num, q;
    mag = (comp < 0) ? -comp : comp;
    num = mag * hw_model * 256;
    q = (2 * num + len) / (2 * len);
    return (comp < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[COORD_W-1:0];
  endfunction

  task automatic queue_result(input quad_item_t r);
    expected_q = {expected_q, r};
  endtask

  task automatic predict_quad();
    longint sx, sy, ex, ey, dx, dy, ox, oy;
    logic [63:0] len;
    logic [INDEX_BITS-1:0] base;
    quad_item_t r;
    sx = in_start_x; sy = in_start_y; ex = in_end_x; ey = in_end_y;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) return;
    len = int_sqrt((dx * dx + dy * dy) << 16);
    ox = offset_of(-dy, len);
    oy = offset_of(dx, len);
    base = vcount_model;
    r = '0;
    r.kind = KIND_VERTEX;
    r.vx = clamp18(sx + ox); r.vy = clamp18(sy + oy); queue_result(r);
    r.vx = clamp18(sx - ox); r.vy = clamp18(sy - oy); queue_result(r);
    r.vx = clamp18(ex - ox); r.vy = clamp18(ey - oy); queue_result(r);
    r.vx = clamp18(ex + ox); r.vy = clamp18(ey + oy); queue_result(r);
    r = '0;
    r.kind = KIND_TRI;
    r.ca = IDX_OUT_W'(base);
    r.cb = IDX_OUT_W'(base + INDEX_BITS'(1));
    r.cc = IDX_OUT_W'(base + INDEX_BITS'(2));
    queue_result(r);
    r.cb = IDX_OUT_W'(base + INDEX_BITS'(2));
    r.cc = IDX_OUT_W'(base + INDEX_BITS'(3));
    r.last = 1'b1;
    queue_result(r);
    vcount_model = base + INDEX_BITS'(4);
    quads_seen++;
  endtask

  always @(posedge clk) begin
    quad_item_t got, exp_r;
    if (!rst_n) begin
      hw_model <= HW_RESET;
      vcount_model = '0;
      expected_q.delete();
      fail_count <= 0;
      quads_seen = 0;
    end else begin
      if (cfg_wr_en) hw_model <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_action == ACTION_RESTART) vcount_model = '0;
        else predict_quad();
      end
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_vert_x, out_vert_y, out_corner_a, out_corner_b,
                out_corner_c, out_last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected k=%0d x=%0d y=%0d a=%0d b=%0d c=%0d l=%0d",
                     $time, exp_r.kind, exp_r.vx, exp_r.vy, exp_r.ca, exp_r.cb,
                     exp_r.cc, exp_r.last);
            $display("%0t:          actual   k=%0d x=%0d y=%0d a=%0d b=%0d c=%0d l=%0d",
                     $time, got.kind, got.vx, got.vy, got.ca, got.cb, got.cc, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== test/tb.sv =====
// Testbench top for thick_segment_to_quad: drives segments, restarts and
// half-width settings with random gaps and stalls. Depends on tsq_pkg, tsq_checker.
`timescale 1ns / 1ps
module tb;
  import tsq_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n, cfg_wr_en, in_valid, in_stall, in_action;
  logic [HW_W-1:0] cfg_wr_data;
  logic signed [COORD_W-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid, out_stall, out_kind, out_last;
  logic signed [COORD_W-1:0] out_vert_x, out_vert_y;
  logic [IDX_OUT_W-1:0] out_corner_a, out_corner_b, out_corner_c;
  int fail_count, pending, quads_seen, idle_cycles, sent;
  logic stall_mode;

  thick_segment_to_quad uut (.*);
  tsq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: alternates between a free-running phase and a random-stall phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("thick_segment_to_quad regression: fail");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 18'sh1FFFF;
      1: return -18'sh20000;
      2: return COORD_W'($urandom_range(0, 255) - 128);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic send(input logic act, input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    in_valid <= 1'b1;
    in_action <= act;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    // bursts: usually keep valid up for the next transaction
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic idle_then_cfg(input logic [HW_W-1:0] hw);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hw;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic rand_item();
    logic signed [COORD_W-1:0] sx, sy;
    int r;
    r = $urandom_range(0, 19);
    sx = rnd_coord(); sy = rnd_coord();
    if (r == 0) send(ACTION_RESTART, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    else if (r == 1) send(1'b0, sx, sy, sx, sy);
    else if (r < 10) send(1'b0, sx, sy, COORD_W'(sx + ($urandom_range(0, 2047) - 1024)),
                          COORD_W'(sy + ($urandom_range(0, 2047) - 1024)));
    else send(1'b0, sx, sy, rnd_coord(), rnd_coord());
  endtask

  initial begin
    logic [HW_W-1:0] hw_set[4];
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0; in_action = 1'b0;
    in_start_x = '0; in_start_y = '0; in_end_x = '0; in_end_y = '0; sent = 0;
    hw_set = '{14'd0, 14'h3FFF, 14'd1, 14'd5000};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // directed: reset half width, axis lines, extremes, zero length, restart
    send(1'b0, '0, '0, 18'sd16384, '0);
    send(1'b0, '0, '0, '0, 18'sd16384);
    send(1'b0, '0, '0, 18'sd1, '0);
    send(1'b0, '0, '0, '0, -18'sd1);
    send(1'b0, -18'sh20000, -18'sh20000, 18'sh1FFFF, 18'sh1FFFF);
    send(1'b0, 18'sh1FFFF, -18'sh20000, -18'sh20000, 18'sh1FFFF);
    send(1'b0, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFE, 18'sh1FFFF);
    send(1'b0, -18'sh20000, -18'sh20000, -18'sh20000, -18'sh1FFFF);
    send(1'b0, 18'sd100, 18'sd100, 18'sd100, 18'sd100);
    send(ACTION_RESTART, 18'sh1FFFF, -18'sh20000, 18'sd5, 18'sd9);
    send(1'b0, 18'sd3, 18'sd7, -18'sd400, 18'sd900);
    idle_then_cfg(14'h3FFF);
    send(1'b0, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFF0);
    send(1'b0, -18'sh20000, 18'sd0, -18'sh1FFF0, 18'sd0);
    idle_then_cfg(14'd0);
    send(1'b0, 18'sd1, 18'sd2, 18'sd3, 18'sd4);
    // index wrap needs 16384 quads, far more than this run sends
    for (int ph = 0; ph < 6; ph++) begin
      idle_then_cfg(ph < 4 ? hw_set[ph] : 14'($urandom));
      for (int i = 0; i < 50; i++) rand_item();
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d input transactions, %0d quads, 9 half-width settings",
             sent, quads_seen);
    if (fail_count == 0) $display("thick_segment_to_quad regression: pass");
    else $display("thick_segment_to_quad regression: fail");
    $finish;
  end
endmodule
